>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that prop holds at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond is never true at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> src/bipc_pkg.sv
// ----------------------------------------------------------------------------
// bipc_pkg
// Types and constants of the isolated pixel cleaner.
// ----------------------------------------------------------------------------
package bipc_pkg;

  // Default frame store geometry
  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;

  // Configuration register defaults and field width
  localparam int          CfgDataW         = 9;
  localparam logic [8:0]  FrameWidthReset  = 9'd64;
  localparam logic [8:0]  FrameHeightReset = 9'd64;

  // Pixel values
  localparam logic [7:0] PixBlack = 8'd0;
  localparam logic [7:0] PixWhite = 8'd255;

  // Reply kinds
  localparam logic ReplyRead = 1'b0;
  localparam logic ReplyDone = 1'b1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // Request types; code 3 is unused
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_CLEAN = 2'd1,
    REQ_READ  = 2'd2
  } req_type_e;

  // Address source of the shared address unit
  typedef enum logic [1:0] {
    ASEL_HOST,
    ASEL_CTR,
    ASEL_NB,
    ASEL_FOUND
  } addr_sel_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_REPLY,
    ST_CTR_RD,
    ST_CTR_CHK,
    ST_NB_RD,
    ST_NB_CHK,
    ST_WR_CTR,
    ST_WR_NB,
    ST_NEXT,
    ST_CLEAN_DONE
  } state_e;

endpackage

>>> src/binary_isolated_pixel_cleaner.sv
// ----------------------------------------------------------------------------
// binary_isolated_pixel_cleaner
// Greyscale frame store with an in-place isolated black pixel clean pass.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o req_type_i col_i row_i pixel_in_i
//   out      source     out_valid_o/out_stall_i reply_kind_o pixel_out_o
//   cfg      sink       cfg_we_i                cfg_idx_i cfg_data_i
//
// A pixel write goes straight into the frame store; a read registers its
// word in the store and waits in READ_REPLY until the output register is
// free. A clean pass walks the interior through one shared address unit
// and the single frame store port: a black pixel's in-frame neighbours are
// read one by one, then it may be written white; a done word ends the pass.
// Reset clears control and configuration; the frame contents stay
// undefined until written, with no clearing pass.
// A finished word waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_isolated_pixel_cleaner #(
  parameter int MAX_WIDTH  = bipc_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bipc_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    col_i,
  input  logic [7:0]                    row_i,
  input  logic [7:0]                    pixel_in_i,
  // reply channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          reply_kind_o,
  output logic [7:0]                    pixel_out_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [bipc_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int CXW   = $clog2(MAX_WIDTH + 1);
  localparam int RXW   = $clog2(MAX_HEIGHT + 1);
  localparam logic [AW-1:0] WidthA  = AW'(MAX_WIDTH);
  localparam logic [1:0]    CntMany = 2'd2;

  // Configuration
  logic [bipc_pkg::CfgDataW-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bipc_pkg::FrameWidthReset;
      frame_height_q <= bipc_pkg::FrameHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bipc_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        bipc_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
      endcase
    end
  end

  // Saturate frame size to the store
  logic [CXW-1:0] w_sat;
  logic [RXW-1:0] h_sat;

  assign w_sat = (int'(frame_width_q) > MAX_WIDTH) ? CXW'(MAX_WIDTH) : CXW'(frame_width_q);
  assign h_sat = (int'(frame_height_q) > MAX_HEIGHT) ? RXW'(MAX_HEIGHT) : RXW'(frame_height_q);

  // Sequencer and scan registers
  bipc_pkg::state_e state_q, state_d;
  logic [CXW-1:0] c_q, c_d, nc_q, nc_d;
  logic [RXW-1:0] r_q, r_d, nr_q, nr_d;
  logic [1:0]     ofs_c_q, ofs_c_d, ofs_r_q, ofs_r_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           phase2_q, phase2_d;
  logic           inside_q, inside_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic       out_kind_q, out_kind_d;
  logic [7:0] out_pix_q, out_pix_d;

  // Frame store port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  bipc_pkg::addr_sel_e asel;

  // Neighbour coordinate of the current base pixel
  logic [CXW-1:0] bx, nbx;
  logic [RXW-1:0] by, nby;
  logic [CXW:0]   tx;
  logic [RXW:0]   ty;
  logic           nb_in;

  assign bx  = phase2_q ? nc_q : c_q;
  assign by  = phase2_q ? nr_q : r_q;
  assign tx  = {1'b0, bx} + (CXW + 1)'(ofs_c_q);
  assign ty  = {1'b0, by} + (RXW + 1)'(ofs_r_q);
  assign nbx = CXW'(tx - 1'b1);
  assign nby = RXW'(ty - 1'b1);
  assign nb_in = (tx != '0) && (ty != '0) && (nbx < w_sat) && (nby < h_sat);

  // Shared address unit: row * store width + column
  logic [AW-1:0] ax, ay;

  always_comb begin
    unique case (asel)
      bipc_pkg::ASEL_HOST: begin
        ax = AW'(col_i);
        ay = AW'(row_i);
      end
      bipc_pkg::ASEL_CTR: begin
        ax = AW'(c_q);
        ay = AW'(r_q);
      end
      bipc_pkg::ASEL_NB: begin
        ax = AW'(nbx);
        ay = AW'(nby);
      end
      bipc_pkg::ASEL_FOUND: begin
        ax = AW'(nc_q);
        ay = AW'(nr_q);
      end
    endcase
  end

  assign ram_addr = ay * WidthA + ax;

  bipc_frame_ram #(
    .DEPTH(Depth),
    .AW   (AW)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Helper terms
  logic       in_acc, host_inside, slot_free;
  logic       hit, do_step, last_ofs;
  logic [1:0] cnt_upd, ofs_c_n, ofs_r_n;

  assign in_acc      = in_valid_i && (state_q == bipc_pkg::ST_IDLE);
  assign host_inside = (int'(col_i) < MAX_WIDTH) && (int'(row_i) < MAX_HEIGHT);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign hit         = (state_q == bipc_pkg::ST_NB_CHK) && (ram_rdata == bipc_pkg::PixBlack);
  assign do_step     = (state_q == bipc_pkg::ST_NB_CHK) ||
                       ((state_q == bipc_pkg::ST_NB_RD) && !nb_in);
  assign last_ofs    = (ofs_c_q == 2'd2) && (ofs_r_q == 2'd2);
  assign cnt_upd     = (hit && (cnt_q != CntMany)) ? cnt_q + 2'd1 : cnt_q;

  // Advance neighbour offset, column outer and row inner, skip the center
  always_comb begin
    ofs_r_n = (ofs_r_q == 2'd2) ? 2'd0 : ofs_r_q + 2'd1;
    ofs_c_n = (ofs_r_q == 2'd2) ? ofs_c_q + 2'd1 : ofs_c_q;
    if ((ofs_c_n == 2'd1) && (ofs_r_n == 2'd1)) begin
      ofs_r_n = 2'd2;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    c_d         = c_q;
    r_d         = r_q;
    nc_d        = nc_q;
    nr_d        = nr_q;
    ofs_c_d     = ofs_c_q;
    ofs_r_d     = ofs_r_q;
    cnt_d       = cnt_q;
    phase2_d    = phase2_q;
    inside_d    = inside_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_pix_d   = out_pix_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = bipc_pkg::PixWhite;
    asel        = bipc_pkg::ASEL_NB;

    unique case (state_q)
      bipc_pkg::ST_IDLE: begin
        asel = bipc_pkg::ASEL_HOST;
        if (in_acc) begin
          unique case (req_type_i)
            bipc_pkg::REQ_WRITE: begin
              ram_we    = host_inside;
              ram_wdata = pixel_in_i;
            end
            bipc_pkg::REQ_CLEAN: begin
              c_d      = CXW'(1);
              r_d      = RXW'(1);
              phase2_d = 1'b0;
              if ((int'(w_sat) < 3) || (int'(h_sat) < 3)) begin
                state_d = bipc_pkg::ST_CLEAN_DONE;
              end else begin
                state_d = bipc_pkg::ST_CTR_RD;
              end
            end
            bipc_pkg::REQ_READ: begin
              ram_re   = host_inside;
              inside_d = host_inside;
              state_d  = bipc_pkg::ST_READ_REPLY;
            end
            default: ;
          endcase
        end
      end

      // Hand the read word to the output register once it is free
      bipc_pkg::ST_READ_REPLY: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = bipc_pkg::ReplyRead;
          out_pix_d   = inside_q ? ram_rdata : 8'd0;
          state_d     = bipc_pkg::ST_IDLE;
        end
      end

      bipc_pkg::ST_CTR_RD: begin
        asel    = bipc_pkg::ASEL_CTR;
        ram_re  = 1'b1;
        state_d = bipc_pkg::ST_CTR_CHK;
      end

      // Only black pixels get a neighbour count
      bipc_pkg::ST_CTR_CHK: begin
        if (ram_rdata == bipc_pkg::PixBlack) begin
          ofs_c_d = 2'd0;
          ofs_r_d = 2'd0;
          cnt_d   = 2'd0;
          state_d = bipc_pkg::ST_NB_RD;
        end else begin
          state_d = bipc_pkg::ST_NEXT;
        end
      end

      bipc_pkg::ST_NB_RD: begin
        if (nb_in) begin
          ram_re  = 1'b1;
          state_d = bipc_pkg::ST_NB_CHK;
        end
      end

      bipc_pkg::ST_NB_CHK: ;

      bipc_pkg::ST_WR_CTR: begin
        asel   = bipc_pkg::ASEL_CTR;
        ram_we = 1'b1;
        state_d = phase2_q ? bipc_pkg::ST_WR_NB : bipc_pkg::ST_NEXT;
      end

      bipc_pkg::ST_WR_NB: begin
        asel    = bipc_pkg::ASEL_FOUND;
        ram_we  = 1'b1;
        state_d = bipc_pkg::ST_NEXT;
      end

      // Advance the scan: row inner, column outer
      bipc_pkg::ST_NEXT: begin
        phase2_d = 1'b0;
        if (({1'b0, r_q} + (RXW + 1)'(2)) < {1'b0, h_sat}) begin
          r_d     = r_q + RXW'(1);
          state_d = bipc_pkg::ST_CTR_RD;
        end else if (({1'b0, c_q} + (CXW + 1)'(2)) < {1'b0, w_sat}) begin
          r_d     = RXW'(1);
          c_d     = c_q + CXW'(1);
          state_d = bipc_pkg::ST_CTR_RD;
        end else begin
          state_d = bipc_pkg::ST_CLEAN_DONE;
        end
      end

      bipc_pkg::ST_CLEAN_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = bipc_pkg::ReplyDone;
          out_pix_d   = 8'd0;
          state_d     = bipc_pkg::ST_IDLE;
        end
      end

      default: state_d = bipc_pkg::ST_IDLE;
    endcase

    // Count one neighbour and decide once the count is settled
    if (do_step) begin
      cnt_d = cnt_upd;
      if (hit && !phase2_q) begin
        nc_d = nbx;
        nr_d = nby;
      end
      if (last_ofs || (cnt_upd == CntMany)) begin
        if (!phase2_q) begin
          priority if (cnt_upd == 2'd0) begin
            state_d = bipc_pkg::ST_WR_CTR;
          end else if (cnt_upd == 2'd1) begin
            phase2_d = 1'b1;
            ofs_c_d  = 2'd0;
            ofs_r_d  = 2'd0;
            cnt_d    = 2'd0;
            state_d  = bipc_pkg::ST_NB_RD;
          end else begin
            state_d = bipc_pkg::ST_NEXT;
          end
        end else begin
          state_d = (cnt_upd == 2'd1) ? bipc_pkg::ST_WR_CTR : bipc_pkg::ST_NEXT;
        end
      end else begin
        ofs_c_d = ofs_c_n;
        ofs_r_d = ofs_r_n;
        state_d = bipc_pkg::ST_NB_RD;
      end
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bipc_pkg::ST_IDLE;
      phase2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase2_q    <= phase2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Scan and reply payload
  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    r_q        <= r_d;
    nc_q       <= nc_d;
    nr_q       <= nr_d;
    ofs_c_q    <= ofs_c_d;
    ofs_r_q    <= ofs_r_d;
    cnt_q      <= cnt_d;
    inside_q   <= inside_d;
    out_kind_q <= out_kind_d;
    out_pix_q  <= out_pix_d;
  end

  assign in_stall_o   = (state_q != bipc_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign reply_kind_o = out_kind_q;
  assign pixel_out_o  = out_pix_q;

  // Assertions
  `ASSERT_CLK(a_chk_after_rd, clk_i, rst_ni, (state_q == bipc_pkg::ST_NB_CHK) |-> ($past(state_q) == bipc_pkg::ST_NB_RD), "neighbour check without a read")
  `ASSERT_CLK(a_scan_interior, clk_i, rst_ni, (state_q == bipc_pkg::ST_CTR_RD) |-> ((c_q != '0) && (r_q != '0) && (({1'b0, c_q} + (CXW + 1)'(2)) <= {1'b0, w_sat})), "scan left the interior")
  `ASSERT_CLK(a_done_zero, clk_i, rst_ni, (out_valid_o && (reply_kind_o == bipc_pkg::ReplyDone)) |-> (pixel_out_o == 8'd0), "clean done word carries a pixel")
  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, ((state_q == bipc_pkg::ST_NB_RD) || (state_q == bipc_pkg::ST_NB_CHK)) && (cnt_q == 2'd3), "neighbour count overflow")

endmodule

>>> src/bipc_frame_ram.sv
// ----------------------------------------------------------------------------
// bipc_frame_ram
// Single-port frame store: one write or one read per cycle, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module bipc_frame_ram #(
  parameter int DEPTH = bipc_pkg::MaxWidthDef * bipc_pkg::MaxHeightDef,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read, hold between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
